// File: rtl/jbsc_pkg.sv
// Package for the block symbol coder: item, job and result types, constants
// and the size category / mantissa function. Used by every module in rtl/.
package jbsc_pkg;

    localparam logic [5:0]         LAST_POS    = 6'd63;
    localparam logic [7:0]         ZRL_SYMBOL  = 8'hF0;
    localparam logic [7:0]         EOB_SYMBOL  = 8'h00;
    localparam logic [11:0]        DC_BASE     = 12'd128;
    localparam logic signed [12:0] MAG_LIMIT   = 13'sd2047;
    localparam logic               ACTION_COEF     = 1'b0;
    localparam logic               ACTION_PRED_RST = 1'b1;

    localparam logic [1:0] TBL_DC_LUMA   = 2'd0;
    localparam logic [1:0] TBL_DC_CHROMA = 2'd1;
    localparam logic [1:0] TBL_AC_LUMA   = 2'd2;
    localparam logic [1:0] TBL_AC_CHROMA = 2'd3;
    localparam logic [1:0] COMP_CR       = 2'd2;
    localparam logic [1:0] COMP_SPARE    = 2'd3;

    typedef struct packed {
        logic              action;
        logic signed [11:0] coefficient;
        logic [1:0]        component;
        logic              block_start;
        logic              block_end;
    } item_t;

    typedef struct packed {
        logic [3:0]  len;
        logic [10:0] bits;
    } code_t;

    typedef struct packed {
        logic [1:0]  val_table;
        logic [1:0]  ac_table;
        logic [1:0]  zrl_cnt;
        logic        has_val;
        logic        has_eob;
        logic [7:0]  symbol;
        logic [10:0] bits;
        logic [3:0]  len;
    } job_t;

    typedef struct packed {
        logic [1:0]  table_select;
        logic [7:0]  symbol;
        logic [10:0] extra_bits;
        logic [3:0]  extra_length;
        logic        last_of_run;
    } result_t;

    // The value must already lie in -2047..2047.
    function automatic code_t code_value(input logic signed [11:0] v);
        logic [10:0] mag;
        logic [11:0] m;
        logic [11:0] mask;
        code_t       c;
        mag = v[11] ? 11'(-v) : 11'(v);
        c.len = 4'd0;
        for (int i = 0; i < 11; i++) begin
            if (mag[i]) begin
                c.len = 4'(i + 1);
            end
        end
        m = v[11] ? 12'(v - 12'sd1) : 12'(v);
        mask = (12'd1 << c.len) - 12'd1;
        c.bits = m[10:0] & mask[10:0];
        return c;
    endfunction

endpackage

// File: rtl/jbsc_ctx.sv
// Block context: DC predictors, zero run and scan position, and the decode
// of one registered coefficient into a job of up to five symbols. Uses jbsc_pkg.
module jbsc_ctx (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           take,
    input  jbsc_pkg::item_t item,
    input  logic [1:0]     dc_precision,
    output logic           job_load,
    output jbsc_pkg::job_t job
);
    import jbsc_pkg::*;

    logic signed [11:0] pred_reg [3];
    logic signed [11:0] pred_next [3];
    logic [5:0]         zero_run_reg, zero_run_next;
    logic [5:0]         scan_reg, scan_next;

    logic [1:0]         comp_idx;
    logic               chroma;
    logic [1:0]         ac_table;
    logic signed [12:0] diff;
    logic signed [11:0] dc_val;
    logic signed [11:0] ac_val;
    code_t              dc_code;
    code_t              ac_code;
    logic [5:0]         pos;
    logic               end_eff;
    logic [5:0]         run_new;
    logic [11:0]        base;

    assign comp_idx = (item.component == COMP_SPARE) ? COMP_CR : item.component;
    assign chroma   = (comp_idx != 2'd0);
    assign ac_table = chroma ? TBL_AC_CHROMA : TBL_AC_LUMA;
    assign base     = DC_BASE << dc_precision;

    assign diff = {item.coefficient[11], item.coefficient}
                - {pred_reg[comp_idx][11], pred_reg[comp_idx]};

    always_comb begin
        if (diff > MAG_LIMIT) begin
            dc_val = 12'sd2047;
        end else if (diff < -MAG_LIMIT) begin
            dc_val = -12'sd2047;
        end else begin
            dc_val = diff[11:0];
        end
        ac_val = (item.coefficient == -12'sd2048) ? -12'sd2047 : item.coefficient;
    end

    assign dc_code = code_value(dc_val);
    assign ac_code = code_value(ac_val);
    assign pos     = scan_reg + 6'd1;

    always_comb begin
        job           = '0;
        job.ac_table  = ac_table;
        job.val_table = ac_table;
        zero_run_next = zero_run_reg;
        scan_next     = scan_reg;
        end_eff       = item.block_end || (pos == LAST_POS);
        run_new       = 6'd0;
        for (int i = 0; i < 3; i++) begin
            pred_next[i] = pred_reg[i];
        end
        if (take) begin
            if (item.action == ACTION_PRED_RST) begin
                for (int i = 0; i < 3; i++) begin
                    pred_next[i] = base;
                end
            end else if (item.block_start) begin
                job.val_table = chroma ? TBL_DC_CHROMA : TBL_DC_LUMA;
                job.has_val   = 1'b1;
                job.symbol    = {4'd0, dc_code.len};
                job.bits      = dc_code.bits;
                job.len       = dc_code.len;
                pred_next[comp_idx] = item.coefficient;
                zero_run_next = 6'd0;
                scan_next     = 6'd0;
                if (item.block_end) begin
                    job.has_eob = 1'b1;
                    scan_next   = LAST_POS;
                end
            end else if (scan_reg != LAST_POS) begin
                if (item.coefficient == 12'sd0) begin
                    run_new = zero_run_reg + 6'd1;
                end else begin
                    job.zrl_cnt = zero_run_reg[5:4];
                    job.has_val = 1'b1;
                    job.symbol  = {zero_run_reg[3:0], ac_code.len};
                    job.bits    = ac_code.bits;
                    job.len     = ac_code.len;
                end
                if (end_eff) begin
                    job.has_eob   = (pos != LAST_POS) || (run_new != 6'd0);
                    zero_run_next = 6'd0;
                    scan_next     = LAST_POS;
                end else begin
                    zero_run_next = run_new;
                    scan_next     = pos;
                end
            end
        end
        job_load = take && (job.has_val || job.has_eob);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pred_reg[i] <= DC_BASE;
            end
            zero_run_reg <= 6'd0;
            scan_reg     <= 6'd0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                pred_reg[i] <= pred_next[i];
            end
            zero_run_reg <= zero_run_next;
            scan_reg     <= scan_next;
        end
    end

endmodule

// File: rtl/jbsc_emit.sv
// Symbol emitter: holds one decoded job and hands its ZRL, value and EOB symbols
// one per cycle, unless the output stalls, to the output register. Uses jbsc_pkg.
module jbsc_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_load,
    input  jbsc_pkg::job_t    job,
    output logic              job_free,
    output logic              out_valid,
    output jbsc_pkg::result_t out_result,
    input  logic              out_ready
);
    import jbsc_pkg::*;

    job_t    job_reg, job_next;
    logic    job_valid_reg, job_valid_next;
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;
    logic    out_load;
    logic    emit;
    logic    last;
    logic [2:0] remaining;

    assign out_load  = !res_valid_reg || out_ready;
    assign emit      = job_valid_reg && out_load;
    assign remaining = 3'(job_reg.zrl_cnt) + 3'(job_reg.has_val) + 3'(job_reg.has_eob);
    assign last      = (remaining == 3'd1);
    assign job_free  = !job_valid_reg || (emit && last);

    always_comb begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        if (out_load) begin
            res_valid_next = job_valid_reg;
            res_next.last_of_run = last;
            if (job_reg.zrl_cnt != 2'd0) begin
                res_next.table_select = job_reg.ac_table;
                res_next.symbol       = ZRL_SYMBOL;
                res_next.extra_bits   = 11'd0;
                res_next.extra_length = 4'd0;
            end else if (job_reg.has_val) begin
                res_next.table_select = job_reg.val_table;
                res_next.symbol       = job_reg.symbol;
                res_next.extra_bits   = job_reg.bits;
                res_next.extra_length = job_reg.len;
            end else begin
                res_next.table_select = job_reg.ac_table;
                res_next.symbol       = EOB_SYMBOL;
                res_next.extra_bits   = 11'd0;
                res_next.extra_length = 4'd0;
            end
        end
        if (emit) begin
            if (job_reg.zrl_cnt != 2'd0) begin
                job_next.zrl_cnt = job_reg.zrl_cnt - 2'd1;
            end else if (job_reg.has_val) begin
                job_next.has_val = 1'b0;
            end
            if (last) begin
                job_valid_next = 1'b0;
            end
        end
        if (job_load) begin
            job_next       = job;
            job_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            res_valid_reg <= res_valid_next;
        end
        job_reg <= job_next;
        res_reg <= res_next;
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

endmodule

// File: rtl/jpeg_block_symbol_coder.sv
// Top level of the JPEG block symbol coder: input register, DC precision
// register, block context and symbol emitter. Uses jbsc_pkg, jbsc_ctx, jbsc_emit.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  coefficient word, tlast = block end
//  m_axis    out  m_axis_tvalid / m_axis_tready  symbol word, tlast = last of word
//  cfg       in   cfg_wr_en                      dc_precision
//
// A word that yields several symbols holds the emitter until it has handed out
// all of them (at most five: three ZRL, a value and an EOB); the emitter takes
// the next job as the last symbol leaves. An accepted word passes through the
// input register and the job register to the output register.
// Reset is synchronous and clears the predictors to 128, the run and the position.
// A stalled m_axis fills the output, job and input registers before s_axis_tready drops.
module jpeg_block_symbol_coder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // coefficient[11:0], component[13:12], zero pad
    input  logic [1:0]  s_axis_tuser,   // action[0], block_start[1]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // symbol[7:0], extra_bits[18:8], extra_length[22:19], pad
    output logic [1:0]  m_axis_tuser,   // table_select[1:0]
    output logic        m_axis_tlast
);
    import jbsc_pkg::*;

    logic       dc_precision_reg;
    logic [1:0] dc_prec_reg;
    item_t      in_reg, in_next;
    logic       in_valid_reg, in_valid_next;
    logic       in_take;
    logic       job_load;
    logic       job_free;
    job_t       job;
    result_t    result;

    assign in_take       = in_valid_reg && job_free;
    assign s_axis_tready = !in_valid_reg || in_take;

    always_comb begin
        in_next       = in_reg;
        in_valid_next = in_valid_reg && !in_take;
        if (s_axis_tvalid && s_axis_tready) begin
            in_next.action      = s_axis_tuser[0];
            in_next.block_start = s_axis_tuser[1];
            in_next.coefficient = s_axis_tdata[11:0];
            in_next.component   = s_axis_tdata[13:12];
            in_next.block_end   = s_axis_tlast;
            in_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            dc_prec_reg      <= 2'd0;
            dc_precision_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                dc_prec_reg      <= cfg_wr_data;
                dc_precision_reg <= 1'b1;
            end
        end
        in_reg <= in_next;
    end

    jbsc_ctx u_ctx (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (in_take),
        .item         (in_reg),
        .dc_precision (dc_precision_reg ? dc_prec_reg : 2'd0),
        .job_load     (job_load),
        .job          (job)
    );

    jbsc_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_load   (job_load),
        .job        (job),
        .job_free   (job_free),
        .out_valid  (m_axis_tvalid),
        .out_result (result),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, result.extra_length, result.extra_bits, result.symbol};
    assign m_axis_tuser = result.table_select;
    assign m_axis_tlast = result.last_of_run;

endmodule

// File: tb/jbsc_symbol_checker.sv
// Checker for the JPEG block symbol coder: watches the coefficient, symbol and
// configuration ports, predicts the symbol words and compares them in order.
// Depends on jbsc_pkg for the result layout, table codes and constants.
module jbsc_symbol_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_words,
    output int          checked_words
);
    timeunit 1ns;
    timeprecision 1ps;
    import jbsc_pkg::*;

    localparam int RUN_CHUNK = 16;
    localparam int REPORT_LIMIT = 10;

    result_t    expected_symbols[$];
    int         dc_pred[3];
    int         zero_run;
    int         scan_pos;
    logic [1:0] dc_prec;
    int         fail_tally;
    int         check_tally;

    function automatic int clamp_mag(input int v);
        if (v > int'(MAG_LIMIT)) return int'(MAG_LIMIT);
        if (v < -int'(MAG_LIMIT)) return -int'(MAG_LIMIT);
        return v;
    endfunction

    function automatic void push_symbol(input logic [1:0] tbl, input logic [7:0] sym,
                                        input logic [10:0] bits, input logic [3:0] len);
        result_t r;
        r.table_select = tbl;
        r.symbol       = sym;
        r.extra_bits   = bits;
        r.extra_length = len;
        r.last_of_run  = 1'b0;
        expected_symbols.push_back(r);
    endfunction

    function automatic void push_value(input logic [1:0] tbl, input int run, input int v);
        int mag;
        int cat;
        int mant;
        mag = (v < 0) ? -v : v;
        cat = 0;
        while (mag != 0) begin
            cat++;
            mag = mag >> 1;
        end
        mant = (v < 0) ? v - 1 : v;
        mant = mant & ((1 << cat) - 1);
        push_symbol(tbl, {4'(run), 4'(cat)}, 11'(mant), 4'(cat));
    endfunction

    task automatic predict_symbols(input logic act, input int coef, input logic [1:0] comp_in,
                                   input logic start, input logic blk_end);
        int         first;
        int         comp;
        int         pos;
        int         i;
        logic       chroma;
        logic       ends;
        logic [1:0] ac_tbl;
        result_t    tail;
        first = expected_symbols.size();
        ends = blk_end;
        if (act == ACTION_PRED_RST) begin
            for (i = 0; i < 3; i++) begin
                dc_pred[i] = int'(DC_BASE) << dc_prec;
            end
            return;
        end
        comp = (comp_in == COMP_SPARE) ? int'(COMP_CR) : int'(comp_in);
        chroma = (comp != 0);
        ac_tbl = chroma ? TBL_AC_CHROMA : TBL_AC_LUMA;
        if (start) begin
            push_value(chroma ? TBL_DC_CHROMA : TBL_DC_LUMA, 0, clamp_mag(coef - dc_pred[comp]));
            dc_pred[comp] = coef;
            zero_run = 0;
            scan_pos = 0;
            if (ends) begin
                push_symbol(ac_tbl, EOB_SYMBOL, 11'd0, 4'd0);
                scan_pos = int'(LAST_POS);
            end
        end else if (scan_pos < int'(LAST_POS)) begin
            pos = scan_pos + 1;
            if (pos >= int'(LAST_POS)) begin
                ends = 1'b1;
            end
            if (coef == 0) begin
                zero_run++;
            end else begin
                while (zero_run >= RUN_CHUNK) begin
                    push_symbol(ac_tbl, ZRL_SYMBOL, 11'd0, 4'd0);
                    zero_run -= RUN_CHUNK;
                end
                push_value(ac_tbl, zero_run, clamp_mag(coef));
                zero_run = 0;
            end
            if (ends) begin
                if (pos < int'(LAST_POS) || zero_run != 0) begin
                    push_symbol(ac_tbl, EOB_SYMBOL, 11'd0, 4'd0);
                end
                zero_run = 0;
                scan_pos = int'(LAST_POS);
            end else begin
                scan_pos = pos;
            end
        end
        if (expected_symbols.size() > first) begin
            tail = expected_symbols.pop_back();
            tail.last_of_run = 1'b1;
            expected_symbols.push_back(tail);
        end
    endtask

    task automatic compare_symbol();
        result_t want;
        result_t got;
        got.table_select = m_axis_tuser;
        got.symbol       = m_axis_tdata[7:0];
        got.extra_bits   = m_axis_tdata[18:8];
        got.extra_length = m_axis_tdata[22:19];
        got.last_of_run  = m_axis_tlast;
        if (expected_symbols.size() == 0) begin
            fail_tally++;
            if (fail_tally <= REPORT_LIMIT) begin
                $display("unexpected symbol word: table %0d symbol %02h bits %03h",
                         got.table_select, got.symbol, got.extra_bits);
                $display("    len %0d last %0b", got.extra_length, got.last_of_run);
            end
        end else begin
            want = expected_symbols.pop_front();
            check_tally++;
            if (got.table_select !== want.table_select || got.symbol !== want.symbol ||
                got.extra_bits !== want.extra_bits || got.extra_length !== want.extra_length ||
                got.last_of_run !== want.last_of_run) begin
                fail_tally++;
                if (fail_tally <= REPORT_LIMIT) begin
                    $display("symbol word %0d mismatch:", check_tally);
                    $display("    expected table %0d symbol %02h bits %03h len %0d last %0b",
                             want.table_select, want.symbol, want.extra_bits,
                             want.extra_length, want.last_of_run);
                    $display("    actual   table %0d symbol %02h bits %03h len %0d last %0b",
                             got.table_select, got.symbol, got.extra_bits, got.extra_length,
                             got.last_of_run);
                end
            end
        end
    endtask

    initial begin
        fail_tally  = 0;
        check_tally = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            dc_pred[0] = int'(DC_BASE);
            dc_pred[1] = int'(DC_BASE);
            dc_pred[2] = int'(DC_BASE);
            zero_run = 0;
            scan_pos = 0;
            dc_prec = 2'd0;
            expected_symbols.delete();
        end else begin
            if (cfg_wr_en) begin
                dc_prec = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_symbols(s_axis_tuser[0], $signed(s_axis_tdata[11:0]),
                                s_axis_tdata[13:12], s_axis_tuser[1], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                compare_symbol();
            end
        end
        fail_count    <= fail_tally;
        pending_words <= expected_symbols.size();
        checked_words <= check_tally;
    end

endmodule

// File: tb/jpeg_block_symbol_coder_tb.sv
// Testbench top for the JPEG block symbol coder: drives coefficient blocks and
// configuration, paces the symbol side and reports the verdict.
// Depends on jbsc_pkg, the RTL top level and jbsc_symbol_checker.
module jpeg_block_symbol_coder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jbsc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_STALL    = 200;
    localparam int PHASE_WORDS   = 36;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending_words;
    int checked_words;
    int cycle_count = 0;
    int words_sent = 0;
    int blocks_sent = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit rx_hold_request = 1'b0;

    always #2 aclk = ~aclk;

    jpeg_block_symbol_coder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    jbsc_symbol_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .checked_words (checked_words)
    );

    task automatic send_word(input logic act, input logic [11:0] coef, input logic [1:0] comp,
                             input logic start, input logic blk_end);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, comp, coef};
        s_axis_tuser  <= {start, act};
        s_axis_tlast  <= blk_end;
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_precision(input logic [1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [11:0] random_coef(input int zero_pct);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 12'd0;
        r = $urandom_range(0, 99);
        if (r < 60) v = $urandom_range(1, 15);
        else if (r < 85) v = $urandom_range(16, 255);
        else return 12'($urandom());
        return $urandom_range(0, 1) ? 12'(0 - v) : 12'(v);
    endfunction

    task automatic send_random_block();
        int         shape;
        int         n_ac;
        int         zero_pct;
        int         i;
        logic [1:0] comp;
        logic       broken;
        logic       tail_flag;
        logic [11:0] dc;
        comp = ($urandom_range(0, 9) == 0) ? COMP_SPARE : 2'($urandom_range(0, 2));
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            n_ac = int'(LAST_POS);
            zero_pct = 75;
        end else if (shape < 30) begin
            n_ac = $urandom_range(17, 40);
            zero_pct = 88;
        end else begin
            n_ac = $urandom_range(0, 10);
            zero_pct = 45;
        end
        broken = ($urandom_range(0, 9) == 0);
        dc = $urandom_range(0, 1) ? 12'($urandom()) : 12'($urandom_range(0, 400) - 200);
        send_word(ACTION_COEF, dc, comp, 1'b1, (n_ac == 0) && !broken);
        for (i = 1; i <= n_ac; i++) begin
            if (i == int'(LAST_POS)) tail_flag = 1'($urandom_range(0, 1));
            else tail_flag = (i == n_ac) && !broken;
            send_word(ACTION_COEF, random_coef(zero_pct), comp, 1'b0, tail_flag);
        end
        blocks_sent++;
        if ($urandom_range(0, 7) == 0) begin
            send_word(ACTION_PRED_RST, 12'($urandom()), 2'($urandom()), 1'($urandom()),
                      1'($urandom()));
        end
        if (!broken && $urandom_range(0, 7) == 0) begin
            send_word(ACTION_COEF, random_coef(30), 2'($urandom()), 1'b0, 1'($urandom()));
        end
    endtask

    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 3) : 0;
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                gap = LONG_STALL;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [1:0] precisions[4];
        int         phase;
        int         i;
        precisions = '{2'd3, 2'd0, 2'd2, 2'd1};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(ACTION_COEF, 12'd5, 2'd1, 1'b0, 1'b0);
        send_word(ACTION_PRED_RST, 12'hABC, COMP_SPARE, 1'b1, 1'b1);
        send_word(ACTION_COEF, 12'h7FF, 2'd0, 1'b1, 1'b0);
        send_word(ACTION_COEF, 12'h800, 2'd0, 1'b0, 1'b0);
        send_word(ACTION_COEF, 12'hFFF, 2'd0, 1'b0, 1'b1);
        send_word(ACTION_COEF, 12'd7, 2'd0, 1'b0, 1'b0);
        send_word(ACTION_COEF, 12'h800, COMP_SPARE, 1'b1, 1'b1);
        send_word(ACTION_COEF, 12'h800, COMP_CR, 1'b1, 1'b0);
        for (i = 0; i < 16; i++) begin
            send_word(ACTION_COEF, 12'd0, COMP_CR, 1'b0, 1'b0);
        end
        send_word(ACTION_COEF, 12'h7FF, COMP_CR, 1'b0, 1'b1);

        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            write_precision(precisions[phase]);
            tx_idle = (phase != 2);
            rx_idle = (phase != 2);
            send_word(ACTION_PRED_RST, 12'($urandom()), 2'($urandom()), 1'b0, 1'b0);
            if (phase == 1) rx_hold_request = 1'b1;
            i = words_sent;
            while (words_sent - i < PHASE_WORDS) begin
                send_random_block();
                if (phase == 3 && $urandom_range(0, 3) == 0) wait_drained();
            end
        end

        wait_drained();
        $display("Summary: %0d coefficient and control words in %0d random blocks,",
                 words_sent, blocks_sent);
        $display("%0d symbol words checked.", checked_words);
        $display("Covered all four DC precision settings, one long output stall and drained pauses.");
        if (fail_count == 0 && pending_words == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
